FILE: rtl/core/eti_pkg.sv
// Shared types and constants of the ephemeris table interpolator.
// Used by the controller, the datapath and the top level.
`default_nettype none
package eti_pkg;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_ZLEN  = 2'd2;

   localparam logic [1:0] RD_MID  = 2'd0;
   localparam logic [1:0] RD_IDX  = 2'd1;
   localparam logic [1:0] RD_IDX1 = 2'd2;

   localparam int unsigned FRAC_BITS = 24;
   localparam logic [63:0] FRAC_MAX  = 64'h3FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic       cap_query;
      logic       srch_init;
      logic       srch_step;
      logic       idx_set;
      logic [1:0] rd_sel;
      logic       cap_a;
      logic       cap_b;
      logic       diff;
      logic       div_start;
      logic       comp_init;
      logic       comp_load;
      logic       mul_step;
      logic       rnd;
      logic       shf;
      logic       sat;
      logic       fin_empty;
      logic       fin_copy;
      logic       publish;
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic cnt_one;
      logic srch_done;
      logic dzero;
      logic div_done;
      logic mul_last;
      logic comp_last;
      logic rsp_busy;
   } sts_type;

endpackage
`default_nettype wire

FILE: rtl/core/eti_if.sv
// Channel interfaces of the interpolator: request, response and register write.
// Depend on nothing; coordinate payload widths follow the COORD_WIDTH parameter.
`default_nettype none
interface eti_req_if #(parameter int COORD_WIDTH = 48);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    cmd;
   logic signed [63:0]            time_req;
   logic signed [COORD_WIDTH-1:0] pos_x;
   logic signed [COORD_WIDTH-1:0] pos_y;
   logic signed [COORD_WIDTH-1:0] pos_z;
   logic signed [COORD_WIDTH-1:0] vel_x;
   logic signed [COORD_WIDTH-1:0] vel_y;
   logic signed [COORD_WIDTH-1:0] vel_z;
   modport source (output valid, cmd, time_req, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   input ready);
   modport sink (input valid, cmd, time_req, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 output ready);
endinterface

interface eti_rsp_if #(parameter int COORD_WIDTH = 48);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] out_pos_x;
   logic signed [COORD_WIDTH-1:0] out_pos_y;
   logic signed [COORD_WIDTH-1:0] out_pos_z;
   logic signed [COORD_WIDTH-1:0] out_vel_x;
   logic signed [COORD_WIDTH-1:0] out_vel_y;
   logic signed [COORD_WIDTH-1:0] out_vel_z;
   logic                          velocity_valid;
   logic [1:0]                    status;
   modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y,
                   out_vel_z, velocity_valid, status, input ready);
   modport sink (input valid, out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y,
                 out_vel_z, velocity_valid, status, output ready);
endinterface

interface eti_csr_if;
   logic valid;
   logic ready;
   logic velocity_enable;
   modport source (output valid, velocity_enable, input ready);
   modport sink (input valid, velocity_enable, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/ephemeris_table_interpolator_core.sv
// Ephemeris table interpolator, top level.
// Channels: req_ch (load / query / clear requests), rsp_ch (one response per
// query), csr_ch (velocity_enable write, always ready, write only while idle).
// Load and clear requests are handled in the idle state; a load into a full
// table is dropped. A query runs: table size check, an upper-bound binary
// search with one RAM read then a compare per step, entry reads and time
// differences, a bit-serial fraction divider, then one interpolated
// component after another (3 components, 6 with velocity). Empty table,
// one-entry table and zero-length intervals skip the divider. The response
// sits in an output register; while it stalls, loads and clears are still
// taken, and the next query runs up to its end and waits there until the
// register is free.
// Reset empties the table and clears velocity_enable; the stores need no
// clearing pass, since a query only uses entries below the fill count.
// Requests are taken one at a time.
`default_nettype none
module ephemeris_table_interpolator_core #(
   parameter int DEPTH       = 1024,
   parameter int COORD_WIDTH = 48
) (
   input wire logic clock,
   input wire logic reset,
   eti_req_if.sink  req_ch,
   eti_rsp_if.source rsp_ch,
   eti_csr_if.sink  csr_ch
);
   eti_pkg::cmd_type              cmd;
   eti_pkg::sts_type              sts;
   logic signed [COORD_WIDTH-1:0] req_pos [3], req_vel [3];
   logic signed [COORD_WIDTH-1:0] rsp_pos [3], rsp_vel [3];

   assign req_pos[0] = req_ch.pos_x;
   assign req_pos[1] = req_ch.pos_y;
   assign req_pos[2] = req_ch.pos_z;
   assign req_vel[0] = req_ch.vel_x;
   assign req_vel[1] = req_ch.vel_y;
   assign req_vel[2] = req_ch.vel_z;

   assign csr_ch.ready = 1'b1;

   eti_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_ch.valid), .req_cmd(req_ch.cmd),
      .req_ready(req_ch.ready), .sts(sts), .cmd(cmd));

   eti_datapath #(.DEPTH(DEPTH), .COORD_WIDTH(COORD_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_time(req_ch.time_req), .req_pos(req_pos), .req_vel(req_vel),
      .csr_valid(csr_ch.valid), .csr_data(csr_ch.velocity_enable),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_pos(rsp_pos), .rsp_vel(rsp_vel),
      .rsp_vv(rsp_ch.velocity_valid), .rsp_status(rsp_ch.status));

   assign rsp_ch.out_pos_x = rsp_pos[0];
   assign rsp_ch.out_pos_y = rsp_pos[1];
   assign rsp_ch.out_pos_z = rsp_pos[2];
   assign rsp_ch.out_vel_x = rsp_vel[0];
   assign rsp_ch.out_vel_y = rsp_vel[1];
   assign rsp_ch.out_vel_z = rsp_vel[2];
endmodule
`default_nettype wire

FILE: rtl/core/eti_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module eti_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

FILE: rtl/core/eti_div.sv
// Bit-serial restoring divider for the interpolation fraction, one bit a cycle.
// Uses eti_pkg for the fraction width and saturation limit.
`default_nettype none
module eti_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] nm,
   input  wire logic [63:0] dm,
   output logic      [63:0] q,
   output logic             done
);
   logic [127:0] dvd_ff;
   logic [63:0]  r_ff, q_ff, dm_ff;
   logic         ovf_ff, busy_ff, done_ff;
   logic [6:0]   cnt_ff;
   logic [63:0]  rs;
   logic         ge;

   assign rs = {r_ff[62:0], dvd_ff[127]};
   assign ge = r_ff[63] || (rs >= dm_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 7'd127) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= 128'(nm) << eti_pkg::FRAC_BITS;
         dm_ff  <= dm;
         r_ff   <= '0;
         q_ff   <= '0;
         ovf_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[126:0], 1'b0};
         r_ff   <= ge ? rs - dm_ff : rs;
         q_ff   <= {q_ff[62:0], ge};
         // a quotient bit past bit 63 means the result saturates
         ovf_ff <= ovf_ff | q_ff[63];
         cnt_ff <= cnt_ff + 7'd1;
      end
   end

   assign q    = (ovf_ff || q_ff > eti_pkg::FRAC_MAX) ? eti_pkg::FRAC_MAX : q_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

FILE: rtl/core/eti_datapath.sv
// Datapath: table memories, binary search registers, fraction divider and the
// serial lerp unit. Depends on eti_pkg, eti_ram and eti_div.
`default_nettype none
module eti_datapath #(
   parameter int DEPTH       = 1024,
   parameter int COORD_WIDTH = 48
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire eti_pkg::cmd_type              cmd,
   output eti_pkg::sts_type                   sts,
   input  wire logic signed [63:0]            req_time,
   input  wire logic signed [COORD_WIDTH-1:0] req_pos [3],
   input  wire logic signed [COORD_WIDTH-1:0] req_vel [3],
   input  wire logic                          csr_valid,
   input  wire logic                          csr_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0]      rsp_pos [3],
   output logic signed [COORD_WIDTH-1:0]      rsp_vel [3],
   output logic                               rsp_vv,
   output logic [1:0]                         rsp_status
);
   localparam int CW  = COORD_WIDTH;
   localparam int AW  = $clog2(DEPTH);
   localparam int CNT = $clog2(DEPTH + 1);

   logic                 ven_ff;
   logic [CNT-1:0]       cnt_ff, lo_ff, hi_ff, mid, idx_w;
   logic [AW-1:0]        idx_ff, raddr;
   logic signed [63:0]   t_ff, ta_ff, tb_ff, t_rd;
   logic [3*CW-1:0]      p_rd, v_rd;
   logic signed [CW-1:0] pa_ff [3], pb_ff [3], va_ff [3], vb_ff [3];
   logic [63:0]          nmag_ff, dmag_ff, fq;
   logic                 fneg_ff, dzero_ff, div_done;
   logic signed [64:0]   n_w, d_w;
   logic [2:0]           k_ff;
   logic [1:0]           kp, kv, pp_ff;
   logic signed [CW-1:0] sel_a, sel_b, ca_ff, sat_v;
   logic signed [CW:0]   cd;
   logic [CW:0]          cd_mag;
   logic [63:0]          cdm_ff, prod;
   logic                 sneg_ff, we, fits;
   logic [127:0]         acc_ff, p_ff;
   logic signed [127:0]  s_ff;
   logic signed [CW-1:0] res_pos_ff [3], res_vel_ff [3];
   logic [1:0]           res_st_ff;
   logic                 res_vv_ff, rsp_valid_ff;
   logic signed [CW-1:0] rsp_pos_ff [3], rsp_vel_ff [3];
   logic                 rsp_vv_ff;
   logic [1:0]           rsp_st_ff;

   assign we = cmd.load && (cnt_ff < CNT'(DEPTH));

   always_comb begin
      unique case (cmd.rd_sel)
         eti_pkg::RD_MID:  raddr = mid[AW-1:0];
         eti_pkg::RD_IDX:  raddr = idx_ff;
         eti_pkg::RD_IDX1: raddr = idx_ff + AW'(1);
         default:          raddr = idx_ff;
      endcase
   end

   eti_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_time (
      .clock(clock), .we(we), .waddr(cnt_ff[AW-1:0]), .wdata(req_time),
      .raddr(raddr), .rdata(t_rd));
   eti_ram #(.WIDTH(3*CW), .DEPTH(DEPTH)) u_pos (
      .clock(clock), .we(we), .waddr(cnt_ff[AW-1:0]),
      .wdata({req_pos[2], req_pos[1], req_pos[0]}), .raddr(raddr), .rdata(p_rd));
   eti_ram #(.WIDTH(3*CW), .DEPTH(DEPTH)) u_vel (
      .clock(clock), .we(we), .waddr(cnt_ff[AW-1:0]),
      .wdata({req_vel[2], req_vel[1], req_vel[0]}), .raddr(raddr), .rdata(v_rd));

   eti_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .nm(nmag_ff), .dm(dmag_ff),
      .q(fq), .done(div_done));

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ven_ff       <= 1'b0;
         cnt_ff       <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            ven_ff <= csr_data;
         end
         if (cmd.clear) begin
            cnt_ff <= '0;
         end else if (we) begin
            cnt_ff <= cnt_ff + CNT'(1);
         end
         if (cmd.srch_init) begin
            lo_ff <= '0;
            hi_ff <= cnt_ff;
         end else if (cmd.srch_step) begin
            if (t_rd > t_ff) begin
               hi_ff <= mid;
            end else begin
               lo_ff <= mid + CNT'(1);
            end
         end
         if (cmd.comp_init) begin
            k_ff <= '0;
         end else if (cmd.sat) begin
            k_ff <= k_ff + 3'd1;
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign mid   = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_w = (lo_ff >= cnt_ff) ? cnt_ff - CNT'(2) :
                  (lo_ff == '0) ? '0 : lo_ff - CNT'(1);
   assign n_w   = {t_ff[63], t_ff} - {ta_ff[63], ta_ff};
   assign d_w   = {tb_ff[63], tb_ff} - {ta_ff[63], ta_ff};

   assign kp = k_ff[1:0];
   assign kv = 2'(k_ff - 3'd3);
   always_comb begin
      if (k_ff < 3'd3) begin
         sel_a = pa_ff[kp];
         sel_b = pb_ff[kp];
      end else begin
         sel_a = va_ff[kv];
         sel_b = vb_ff[kv];
      end
   end
   assign cd     = {sel_b[CW-1], sel_b} - {sel_a[CW-1], sel_a};
   assign cd_mag = cd[CW] ? (CW+1)'(-cd) : (CW+1)'(cd);
   assign prod   = {32'd0, cdm_ff[{pp_ff[1], 5'd0} +: 32]} * {32'd0, fq[{pp_ff[0], 5'd0} +: 32]};

   assign fits  = (&s_ff[127:CW-1]) | ~(|s_ff[127:CW-1]);
   assign sat_v = fits ? s_ff[CW-1:0] :
                  (s_ff[127] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.cap_query) begin
         t_ff <= req_time;
      end
      if (cmd.idx_set) begin
         idx_ff <= idx_w[AW-1:0];
      end
      for (int i = 0; i < 3; i++) begin
         if (cmd.cap_a) begin
            pa_ff[i] <= p_rd[i*CW +: CW];
            va_ff[i] <= v_rd[i*CW +: CW];
         end
         if (cmd.cap_b) begin
            pb_ff[i] <= p_rd[i*CW +: CW];
            vb_ff[i] <= v_rd[i*CW +: CW];
         end
      end
      if (cmd.cap_a) begin
         ta_ff <= t_rd;
      end
      if (cmd.cap_b) begin
         tb_ff <= t_rd;
      end
      if (cmd.diff) begin
         nmag_ff  <= n_w[64] ? 64'(-n_w) : n_w[63:0];
         dmag_ff  <= d_w[64] ? 64'(-d_w) : d_w[63:0];
         fneg_ff  <= n_w[64] ^ d_w[64];
         dzero_ff <= (d_w == '0);
      end
      if (cmd.comp_load) begin
         cdm_ff  <= 64'(cd_mag);
         sneg_ff <= cd[CW] ^ fneg_ff;
         ca_ff   <= sel_a;
         acc_ff  <= '0;
         pp_ff   <= '0;
      end else if (cmd.mul_step) begin
         acc_ff <= acc_ff + (128'(prod) << {({1'b0, pp_ff[1]} + {1'b0, pp_ff[0]}), 5'd0});
         pp_ff  <= pp_ff + 2'd1;
      end
      if (cmd.rnd) begin
         p_ff <= (sneg_ff ? -acc_ff : acc_ff) + (128'(1) << (eti_pkg::FRAC_BITS - 1));
      end
      if (cmd.shf) begin
         s_ff <= ($signed(p_ff) >>> eti_pkg::FRAC_BITS) + 128'(ca_ff);
      end
      if (cmd.fin_empty) begin
         for (int i = 0; i < 3; i++) begin
            res_pos_ff[i] <= '0;
            res_vel_ff[i] <= '0;
         end
         res_st_ff <= eti_pkg::ST_EMPTY;
         res_vv_ff <= 1'b0;
      end else if (cmd.fin_copy) begin
         for (int i = 0; i < 3; i++) begin
            res_pos_ff[i] <= pa_ff[i];
            res_vel_ff[i] <= ven_ff ? va_ff[i] : '0;
         end
         res_st_ff <= sts.cnt_one ? eti_pkg::ST_OK : eti_pkg::ST_ZLEN;
         res_vv_ff <= ven_ff;
      end else if (cmd.comp_init) begin
         for (int i = 0; i < 3; i++) begin
            res_vel_ff[i] <= '0;
         end
         res_st_ff <= eti_pkg::ST_OK;
         res_vv_ff <= ven_ff;
      end else if (cmd.sat) begin
         if (k_ff < 3'd3) begin
            res_pos_ff[kp] <= sat_v;
         end else begin
            res_vel_ff[kv] <= sat_v;
         end
      end
      if (cmd.publish) begin
         rsp_pos_ff <= res_pos_ff;
         rsp_vel_ff <= res_vel_ff;
         rsp_vv_ff  <= res_vv_ff;
         rsp_st_ff  <= res_st_ff;
      end
   end

   assign sts.cnt_zero  = (cnt_ff == '0);
   assign sts.cnt_one   = (cnt_ff == CNT'(1));
   assign sts.srch_done = (lo_ff >= hi_ff);
   assign sts.dzero     = dzero_ff;
   assign sts.div_done  = div_done;
   assign sts.mul_last  = (pp_ff == 2'd3);
   assign sts.comp_last = ven_ff ? (k_ff == 3'd5) : (k_ff == 3'd2);
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pos    = rsp_pos_ff;
   assign rsp_vel    = rsp_vel_ff;
   assign rsp_vv     = rsp_vv_ff;
   assign rsp_status = rsp_st_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT'(DEPTH)) else $error("entry count past depth");
   a_search_order: assert property (@(posedge clock) disable iff (reset)
      cmd.srch_step |=> lo_ff <= hi_ff) else $error("search bounds crossed");
   a_comp_range: assert property (@(posedge clock) disable iff (reset)
      cmd.sat |-> k_ff <= 3'd5) else $error("component index out of range");
endmodule
`default_nettype wire

FILE: rtl/core/eti_ctrl.sv
// Controller state machine: sequences load, clear and query requests over the
// datapath. Depends on eti_pkg for command and status structs.
`default_nettype none
module eti_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [1:0]       req_cmd,
   output logic                  req_ready,
   input  wire eti_pkg::sts_type sts,
   output eti_pkg::cmd_type      cmd
);
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_QSTART = 5'd1;
   localparam logic [4:0] S_SRD    = 5'd2;
   localparam logic [4:0] S_SCMP   = 5'd3;
   localparam logic [4:0] S_IDX    = 5'd4;
   localparam logic [4:0] S_RDA    = 5'd5;
   localparam logic [4:0] S_RDB    = 5'd6;
   localparam logic [4:0] S_CAPB   = 5'd7;
   localparam logic [4:0] S_DIFF   = 5'd8;
   localparam logic [4:0] S_DECIDE = 5'd9;
   localparam logic [4:0] S_COPY   = 5'd10;
   localparam logic [4:0] S_DIV    = 5'd11;
   localparam logic [4:0] S_CLOAD  = 5'd12;
   localparam logic [4:0] S_MUL    = 5'd13;
   localparam logic [4:0] S_RND    = 5'd14;
   localparam logic [4:0] S_SHF    = 5'd15;
   localparam logic [4:0] S_SAT    = 5'd16;
   localparam logic [4:0] S_OUT    = 5'd17;

   logic [4:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = eti_pkg::RD_MID;
      state_in   = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  eti_pkg::CMD_LOAD:  cmd.load = 1'b1;
                  eti_pkg::CMD_CLEAR: cmd.clear = 1'b1;
                  eti_pkg::CMD_QUERY: begin
                     cmd.cap_query = 1'b1;
                     state_in      = S_QSTART;
                  end
                  default: ;
               endcase
            end
         end
         S_QSTART: begin
            cmd.srch_init = 1'b1;
            if (sts.cnt_zero) begin
               cmd.fin_empty = 1'b1;
               state_in      = S_OUT;
            end else if (sts.cnt_one) begin
               state_in = S_IDX;
            end else begin
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            state_in = sts.srch_done ? S_IDX : S_SCMP;
         end
         S_SCMP: begin
            cmd.srch_step = 1'b1;
            state_in      = S_SRD;
         end
         S_IDX: begin
            cmd.idx_set = 1'b1;
            state_in    = S_RDA;
         end
         S_RDA: begin
            cmd.rd_sel = eti_pkg::RD_IDX;
            state_in   = S_RDB;
         end
         S_RDB: begin
            cmd.rd_sel = eti_pkg::RD_IDX1;
            cmd.cap_a  = 1'b1;
            state_in   = S_CAPB;
         end
         S_CAPB: begin
            cmd.cap_b = 1'b1;
            state_in  = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (sts.cnt_one || sts.dzero) begin
               state_in = S_COPY;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_COPY: begin
            cmd.fin_copy = 1'b1;
            state_in     = S_OUT;
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.comp_init = 1'b1;
               state_in      = S_CLOAD;
            end
         end
         S_CLOAD: begin
            cmd.comp_load = 1'b1;
            state_in      = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (sts.mul_last) begin
               state_in = S_RND;
            end
         end
         S_RND: begin
            cmd.rnd  = 1'b1;
            state_in = S_SHF;
         end
         S_SHF: begin
            cmd.shf  = 1'b1;
            state_in = S_SAT;
         end
         S_SAT: begin
            cmd.sat  = 1'b1;
            state_in = sts.comp_last ? S_OUT : S_CLOAD;
         end
         S_OUT: begin
            // hold the result until the response register is free
            if (!sts.rsp_busy) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !sts.rsp_busy) else $error("response overwritten");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.dzero && !sts.cnt_one) else $error("divide by zero length");
   a_query_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SAT && sts.comp_last) |=> state_ff == S_OUT)
      else $error("lerp did not finish into output");
endmodule
`default_nettype wire
